[src/egd_pkg.sv]
// shared types and constants for the exp-golomb decoder with escape removal
// no dependencies; imported by every module of the block
package egd_pkg;

  localparam int BYTE_W           = 8;
  localparam int CODE_W           = 32;
  localparam int MAX_PREFIX_ZEROS = 31;
  localparam int PZ_W             = $clog2(MAX_PREFIX_ZEROS + 1);
  localparam int BIT_CNT_W        = $clog2(BYTE_W);
  localparam int HIST_W           = 2;

  localparam logic [BYTE_W-1:0] ESCAPE_BYTE = BYTE_W'(3);
  localparam logic [PZ_W-1:0]   PZ_MAX      = PZ_W'(MAX_PREFIX_ZEROS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  // partial code being decoded
  typedef struct packed {
    logic              in_suffix;
    logic [PZ_W-1:0]   prefix_zeros;
    logic [CODE_W-1:0] suffix_accum;
    logic [PZ_W-1:0]   suffix_left;
  } dec_state_t;

  // one completed code
  typedef struct packed {
    logic [CODE_W-1:0]        code_number;
    logic signed [CODE_W-1:0] signed_number;
    logic                     prefix_error;
  } result_t;

  // control from sequencer to output stage
  typedef struct packed {
    logic step_res;  // a bit step retires and completes a code
    logic flush;     // move pending code out as last of byte
  } oq_ctrl_t;

  // status from output stage to sequencer
  typedef struct packed {
    logic pend_valid;
    logic out_free;
  } oq_stat_t;

  localparam dec_state_t DEC_CLEAR = '{
    in_suffix:    1'b0,
    prefix_zeros: '0,
    suffix_accum: '0,
    suffix_left:  '0
  };

endpackage

[src/egd_bit_unit.sv]
// one-bit exp-golomb decode step, reused for every bit of a byte
// depends on egd_pkg
module egd_bit_unit (
  input  egd_pkg::dec_state_t cur,
  input  logic                bit_in,
  output egd_pkg::dec_state_t nxt,
  output logic                res_valid,
  output egd_pkg::result_t    res
);
  import egd_pkg::*;

  logic [CODE_W-1:0]        acc_shift;
  logic [CODE_W-1:0]        half;
  logic signed [CODE_W-1:0] sgn;

  assign acc_shift = {cur.suffix_accum[CODE_W-2:0], bit_in};
  assign half      = {1'b0, acc_shift[CODE_W-1:1]};
  // v = acc - 1: odd v maps to acc/2, even v to -(acc/2)
  assign sgn       = acc_shift[0] ? $signed(-half) : $signed(half);

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '{code_number: '0, signed_number: '0, prefix_error: 1'b0};
    if (!cur.in_suffix) begin
      if (!bit_in) begin
        if (cur.prefix_zeros == PZ_MAX) begin
          res_valid        = 1'b1;
          res.prefix_error = 1'b1;
          nxt              = DEC_CLEAR;
        end else begin
          nxt.prefix_zeros = cur.prefix_zeros + PZ_W'(1);
        end
      end else if (cur.prefix_zeros == '0) begin
        // zero-length prefix gives code 0 at once
        res_valid = 1'b1;
        nxt       = DEC_CLEAR;
      end else begin
        nxt.in_suffix    = 1'b1;
        nxt.suffix_left  = cur.prefix_zeros;
        nxt.suffix_accum = CODE_W'(1);
      end
    end else begin
      nxt.suffix_accum = acc_shift;
      nxt.suffix_left  = cur.suffix_left - PZ_W'(1);
      if (cur.suffix_left == PZ_W'(1)) begin
        res_valid         = 1'b1;
        res.code_number   = acc_shift - CODE_W'(1);
        res.signed_number = sgn;
        nxt               = DEC_CLEAR;
      end
    end
  end

endmodule

[src/egd_out_stage.sv]
// pending-code register and output register; holds back one code so the
// last code of a byte can be marked
// depends on egd_pkg
module egd_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  egd_pkg::oq_ctrl_t     ctrl,
  input  egd_pkg::result_t      res,
  output egd_pkg::oq_stat_t     stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // code_number, signed_number
  output logic                  out_tuser,  // prefix_error
  output logic                  out_tlast   // last_of_byte
);
  import egd_pkg::*;

  logic    pend_valid_r, pend_valid_nxt;
  result_t pend_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r;
  logic    out_last_r;
  logic    push_mid;
  logic    push_last;

  assign stat.pend_valid = pend_valid_r;
  assign stat.out_free   = !out_valid_r || out_tready;

  assign push_mid  = ctrl.step_res && pend_valid_r;
  assign push_last = ctrl.flush;

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (ctrl.step_res) begin
      pend_valid_nxt = 1'b1;
    end else if (ctrl.flush) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push_mid || push_last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_res) begin
      pend_r <= res;
    end
    if (push_mid || push_last) begin
      out_r      <= pend_r;
      out_last_r <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.signed_number, out_r.code_number};
  assign out_tuser  = out_r.prefix_error;
  assign out_tlast  = out_last_r;

endmodule

[src/exp_golomb_decoder_with_escape_removal.sv]
// top level: escape-byte removal, bit sequencer and exp-golomb result stream
// depends on egd_pkg, egd_bit_unit, egd_out_stage
//
//  channel | dir | data                                   | side bits
//  --------+-----+----------------------------------------+----------------------------
//  in_     | in  | tdata[7:0] in_byte                     | tuser unit_start
//  out_    | out | tdata[31:0] code, tdata[63:32] signed  | tuser prefix_error,
//          |     |                                        | tlast last_of_byte
//
// a kept byte is accepted, then stepped one bit per cycle through the shared
// bit unit unless a stall holds it, then its last code is flushed if one is
// still pending; an escape byte is dropped as it is accepted
// in_tready is high only while idle; a code waiting for the output register
// stalls the bit loop until out_tready frees it
// synchronous active-low reset clears control state and the decoder state
module exp_golomb_decoder_with_escape_removal (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  input  logic        in_tuser,   // unit_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // code_number [31:0], signed_number [63:32]
  output logic        out_tuser,  // prefix_error
  output logic        out_tlast   // last_of_byte
);
  import egd_pkg::*;

  state_t                 state_r, state_nxt;
  logic [HIST_W-1:0]      hist_r, hist_nxt;
  logic [BYTE_W-1:0]      shreg_r, shreg_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  dec_state_t             dec_r, dec_nxt;

  logic                   accept;
  logic [HIST_W-1:0]      hist_in;
  dec_state_t             dec_in;
  logic                   is_escape;
  logic                   last_bit;

  dec_state_t             step_nxt;
  logic                   step_res;
  result_t                step_out;
  logic                   stall;
  logic                   step_go;
  logic                   flush_go;

  oq_ctrl_t               oq_ctrl;
  oq_stat_t               oq_stat;

  // unit start clears history and partial code before the byte is looked at
  assign accept    = in_tvalid && in_tready;
  assign hist_in   = in_tuser ? '0 : hist_r;
  assign dec_in    = in_tuser ? DEC_CLEAR : dec_r;
  assign is_escape = (in_tdata == ESCAPE_BYTE) && (hist_in == '1);
  assign last_bit  = (cnt_r == '1);

  egd_bit_unit u_bit (
    .cur       (dec_r),
    .bit_in    (shreg_r[BYTE_W-1]),
    .nxt       (step_nxt),
    .res_valid (step_res),
    .res       (step_out)
  );

  // a new code with one already pending needs the output register free
  assign stall = step_res && oq_stat.pend_valid && !oq_stat.out_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !is_escape) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (!stall && last_bit) begin
          state_nxt = (oq_stat.pend_valid || step_res) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!oq_stat.pend_valid || oq_stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    step_go   = 1'b0;
    flush_go  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_RUN:   step_go   = !stall;
      ST_FLUSH: flush_go  = oq_stat.pend_valid && oq_stat.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // byte-level datapath
  always_comb begin
    hist_nxt  = hist_r;
    shreg_nxt = shreg_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    if (accept) begin
      dec_nxt = dec_in;
      if (is_escape) begin
        // escape byte dropped, history shifts in a non-zero entry
        hist_nxt = {hist_in[0], 1'b0};
      end else begin
        hist_nxt  = {hist_in[0], (in_tdata == '0)};
        shreg_nxt = in_tdata;
        cnt_nxt   = '0;
      end
    end else if (step_go) begin
      dec_nxt   = step_nxt;
      shreg_nxt = {shreg_r[BYTE_W-2:0], 1'b0};
      cnt_nxt   = cnt_r + BIT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      hist_r  <= '0;
      dec_r   <= DEC_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      hist_r  <= hist_nxt;
      dec_r   <= dec_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r <= shreg_nxt;
  end

  assign oq_ctrl.step_res = step_go && step_res;
  assign oq_ctrl.flush    = flush_go;

  egd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (oq_ctrl),
    .res        (step_out),
    .stat       (oq_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[verif/tb.sv]
// self-checking testbench for the exp-golomb decoder with escape removal
// keeps its own bit-level decoder state and checks every result beat in order
// depends on egd_pkg and exp_golomb_decoder_with_escape_removal
module tb;
  import egd_pkg::*;

  localparam int RUN_LIMIT  = 300000;  // cycles before the run is declared hung
  localparam int SETTLE_CYC = 20;      // cycles waited after the last expected beat

  // one expected result beat
  typedef struct packed {
    result_t res;
    logic    last;
  } code_exp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // in_byte
  logic        in_tuser = 1'b0; // unit_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // code_number [31:0], signed_number [63:32]
  logic        out_tuser;       // prefix_error
  logic        out_tlast;       // last_of_byte

  // predicted decoder state
  logic [1:0]  zero_hist = '0;
  logic        in_sfx = 1'b0;
  int          pz_cnt = 0;
  logic [31:0] sfx_acc = '0;
  int          sfx_left = 0;

  code_exp_t   exp_codes[$];
  bit          failed = 1'b0;
  bit          calm = 1'b0;      // no idling on either side while set
  int          items_sent = 0;
  int          cycle_cnt = 0;

  exp_golomb_decoder_with_escape_removal uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
  end

  function automatic code_exp_t make_code(input logic [31:0] v, input logic err);
    code_exp_t c;
    c.res.code_number   = err ? '0 : v;
    c.res.signed_number = err ? '0 : (v[0] ? (v >> 1) + 32'd1 : 32'd0 - (v >> 1));
    c.res.prefix_error  = err;
    c.last              = 1'b0;
    return c;
  endfunction

  task automatic clear_partial();
    in_sfx   = 1'b0;
    pz_cnt   = 0;
    sfx_acc  = '0;
    sfx_left = 0;
  endtask

  // walk one accepted byte through the decoder, msb first
  task automatic predict_codes(input logic [7:0] b, input logic st);
    code_exp_t got[$];
    if (st) begin
      zero_hist = '0;
      clear_partial();
    end
    // emulation-prevention byte: dropped, history shifts in a non-zero
    if (b == ESCAPE_BYTE && zero_hist == 2'b11) begin
      zero_hist = {zero_hist[0], 1'b0};
      return;
    end
    zero_hist = {zero_hist[0], b == 8'h00};
    for (int i = 7; i >= 0; i--) begin
      if (!in_sfx) begin
        if (!b[i]) begin
          pz_cnt++;
          if (pz_cnt > MAX_PREFIX_ZEROS) begin
            got.push_back(make_code('0, 1'b1));
            clear_partial();
          end
        end else if (pz_cnt == 0) begin
          got.push_back(make_code('0, 1'b0));
          clear_partial();
        end else begin
          in_sfx   = 1'b1;
          sfx_left = pz_cnt;
          sfx_acc  = 32'd1;
        end
      end else begin
        sfx_acc = {sfx_acc[30:0], b[i]};
        if (sfx_left > 0) sfx_left--;
        if (sfx_left == 0) begin
          got.push_back(make_code(sfx_acc - 32'd1, 1'b0));
          clear_partial();
        end
      end
    end
    if (got.size() > 0) got[got.size()-1].last = 1'b1;
    foreach (got[k]) exp_codes.push_back(got[k]);
  endtask

  // drive one byte beat and wait for its handshake
  task automatic send_byte(input logic [7:0] b, input logic st);
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= st;
    do @(posedge clk); while (!in_tready);
    predict_codes(b, st);
    items_sent++;
  endtask

  // stop sending and let every expected beat come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (exp_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // encode random values as a unit, mostly well-formed, with escape bytes inserted
  task automatic send_coded_unit(input int nbytes);
    bit          bs[$];
    logic [31:0] x;
    logic [7:0]  byt;
    int          n;
    int          r;
    int          zrun;
    bit          first;
    while (bs.size() < nbytes * 8) begin
      r = $urandom_range(99);
      if (r < 60)      n = $urandom_range(3, 0);
      else if (r < 90) n = $urandom_range(12, 4);
      else             n = $urandom_range(31, 13);
      x = (32'd1 << n) | ($urandom() & ((32'd1 << n) - 32'd1));
      repeat (n) bs.push_back(1'b0);
      for (int j = n; j >= 0; j--) bs.push_back(x[j]);
    end
    // pad with zero-prefix codes up to a whole byte
    while (bs.size() % 8 != 0) bs.push_back(1'b1);
    zrun  = 0;
    first = 1'b1;
    while (bs.size() != 0) begin
      for (int j = 7; j >= 0; j--) byt[j] = bs.pop_front();
      // an occasional damaged byte
      if ($urandom_range(99) < 3) byt = 8'($urandom_range(255));
      if (zrun >= 2 && byt <= 8'h03) begin
        send_byte(ESCAPE_BYTE, first);
        first = 1'b0;
        zrun  = 0;
      end
      send_byte(byt, first);
      first = 1'b0;
      zrun  = (byt == 8'h00) ? zrun + 1 : 0;
    end
  endtask

  task automatic test_directed();
    send_byte(8'hff, 1'b1);   // eight zero-prefix codes from one byte
    // 31 zeros then the marker bit, then an all-ones suffix: largest code
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hfe, 1'b0);
    // prefix too long, then counting restarts
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // escape dropped, the 0x03 right after it is kept
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b0);
    // unit start drops a partial code
    send_byte(8'h80, 1'b1);
    send_byte(8'h40, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h7f, 1'b0);
    // unit start clears the zero history, so this 0x03 is data
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h01, 1'b0);
  endtask

  task automatic test_coded_units();
    while (items_sent < 185) begin
      if ($urandom_range(9) == 0) send_coded_unit(24);
      else                        send_coded_unit($urandom_range(10, 2));
    end
  endtask

  // raw bytes, biased toward zero runs and escape candidates
  task automatic test_noise();
    int r;
    logic [7:0] b;
    repeat (50) begin
      r = $urandom_range(99);
      if (r < 35)      b = 8'h00;
      else if (r < 45) b = ESCAPE_BYTE;
      else if (r < 55) b = 8'($urandom_range(2, 1));
      else             b = 8'($urandom_range(255));
      send_byte(b, $urandom_range(7) == 0);
    end
  endtask

  // a stretch with no idling, a full drain, then more traffic
  task automatic test_drain_pause();
    calm = 1'b1;
    repeat (4) send_coded_unit($urandom_range(8, 4));
    calm = 1'b0;
    wait_drained();
    repeat (2) send_coded_unit($urandom_range(8, 2));
  endtask

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    code_exp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_codes.size() == 0) begin
        $error("unexpected beat: code_number %h", out_tdata[31:0]);
        failed = 1'b1;
      end else begin
        e = exp_codes.pop_front();
        if (out_tdata[31:0] !== e.res.code_number) begin
          $error("code_number: expected %h, got %h", e.res.code_number, out_tdata[31:0]);
          failed = 1'b1;
        end
        if (out_tdata[63:32] !== e.res.signed_number) begin
          $error("signed_number: expected %h, got %h",
                 e.res.signed_number, out_tdata[63:32]);
          failed = 1'b1;
        end
        if (out_tuser !== e.res.prefix_error) begin
          $error("prefix_error: expected %b, got %b", e.res.prefix_error, out_tuser);
          failed = 1'b1;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_byte: expected %b, got %b", e.last, out_tlast);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_coded_units();
    test_noise();
    test_drain_pause();
    wait_drained();
    if (!failed && exp_codes.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
